FILE: hw/rtl/cmr_pkg.sv
package cmr_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 320;

    // Wide enough for any byte position of the largest supported buffer.
    localparam int POS_W = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] TYPE_START      = 4'hA;
    localparam logic [3:0] TYPE_DATA       = 4'hB;
    localparam logic [3:0] START_HEADER    = 4'd4;
    localparam logic [3:0] DATA_HEADER     = 4'd1;
    localparam logic [3:0] MAX_FRAME_BYTES = 4'd8;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [2:0]       count;
        logic [55:0]      bytes;
        logic             emit;
        logic [7:0]       kind;
        logic [POS_W-1:0] len;
    } t_cmd;

endpackage

FILE: hw/rtl/cmr_front.sv
module cmr_front #(
    parameter int MAX_MESSAGE_BYTES = cmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [3:0]    i_frame_bytes,
    input  logic [63:0]   i_frame_payload,
    input  logic          i_full,
    output logic          o_push,
    output cmr_pkg::t_cmd o_cmd
);
    import cmr_pkg::*;

    localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic             r_open;
    logic [3:0]       r_tid;
    logic [7:0]       r_kind;
    logic [LEN_W-1:0] r_exp;
    logic [LEN_W-1:0] r_stored;

    logic             accept;
    logic [3:0]       n_eff;
    logic [3:0]       ftype;
    logic [3:0]       tid;
    logic [15:0]      exp_raw;
    logic             start_hit;
    logic             len_ok;
    logic             data_hit;
    logic [3:0]       avail;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] base;
    logic [2:0]       count;
    logic [LEN_W-1:0] new_stored;
    logic             emit;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_eff     = (i_frame_bytes > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : i_frame_bytes;
        ftype     = i_frame_payload[7:4];
        tid       = i_frame_payload[3:0];
        exp_raw   = i_frame_payload[31:16];
        start_hit = (ftype == TYPE_START) && (n_eff >= START_HEADER);
        len_ok    = exp_raw <= 16'(MAX_MESSAGE_BYTES);
        data_hit  = (ftype == TYPE_DATA) && r_open && (r_tid == tid) && (n_eff != 4'd0);
        if (start_hit) begin
            avail = n_eff - START_HEADER;
            total = exp_raw[LEN_W-1:0];
            limit = exp_raw[LEN_W-1:0];
            base  = '0;
        end else begin
            avail = n_eff - DATA_HEADER;
            total = r_exp;
            limit = r_exp - r_stored;
            base  = r_stored;
        end
        count      = (LEN_W'(avail) > limit) ? limit[2:0] : avail[2:0];
        new_stored = base + LEN_W'(count);
        emit       = new_stored == total;

        o_cmd.pos   = POS_W'(base);
        o_cmd.count = count;
        o_cmd.bytes = start_hit ? {24'd0, i_frame_payload[63:32]} : i_frame_payload[63:8];
        o_cmd.emit  = emit;
        o_cmd.kind  = start_hit ? i_frame_payload[15:8] : r_kind;
        o_cmd.len   = POS_W'(total);
        o_push      = accept && ((start_hit && len_ok) || data_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_tid    <= '0;
            r_kind   <= '0;
            r_exp    <= '0;
            r_stored <= '0;
        end else if (accept) begin
            if (start_hit) begin
                r_tid    <= tid;
                r_kind   <= i_frame_payload[15:8];
                r_exp    <= exp_raw[LEN_W-1:0];
                r_stored <= len_ok ? new_stored : '0;
                r_open   <= len_ok && !emit;
            end else if (data_hit) begin
                r_stored <= new_stored;
                r_open   <= !emit;
            end
        end
    end

endmodule

FILE: hw/rtl/cmr_queue.sv
module cmr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cmr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cmr_pkg::t_cmd o_cmd
);
    import cmr_pkg::*;

    t_cmd                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_fill;
    logic                   do_pop;

    assign o_full  = r_fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/cmr_back.sv
module cmr_back #(
    parameter int MAX_MESSAGE_BYTES = cmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  cmr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_message_kind,
    output logic [8:0]    o_message_length,
    output logic [5:0]    o_word_number,
    output logic [63:0]   o_word_bytes,
    output logic          o_final_word
);
    import cmr_pkg::*;

    localparam int AW  = $clog2(MAX_MESSAGE_BYTES);
    localparam int P_W = $clog2(MAX_MESSAGE_BYTES + 8) + 1;
    localparam int WN_W = P_W - 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_OUT
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [P_W-1:0]  r_pos;
    logic [3:0]      r_lane;
    logic [WN_W-1:0] r_word;
    logic [63:0]     r_buf;
    logic            r_rd_pend;
    logic [2:0]      r_rd_lane;
    logic [7:0]      r_mem [MAX_MESSAGE_BYTES];
    logic [7:0]      r_mem_q;

    logic            wr_en;
    logic            rd_en;
    logic            out_free;
    logic            last_word;
    logic [P_W-1:0]  msg_len;

    always_comb begin
        msg_len   = P_W'(r_cmd.len);
        wr_en     = (r_state == S_WRITE) && (r_lane[2:0] < r_cmd.count);
        rd_en     = (r_state == S_READ) && !r_lane[3] && (r_pos < msg_len);
        out_free  = !o_valid || i_ready;
        last_word = r_pos >= msg_len;
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos[AW-1:0]] <= r_cmd.bytes[r_lane[2:0]*8 +: 8];
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_rd_pend <= rd_en;
            r_rd_lane <= r_lane[2:0];
            if (r_rd_pend) begin
                r_buf[r_rd_lane*8 +: 8] <= r_mem_q;
            end
            if (o_valid && i_ready && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_pos   <= P_W'(i_cmd.pos);
                        r_lane  <= '0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (wr_en) begin
                        r_lane <= r_lane + 1'b1;
                        r_pos  <= r_pos + 1'b1;
                    end else if (r_cmd.emit) begin
                        r_pos   <= '0;
                        r_lane  <= '0;
                        r_word  <= '0;
                        r_buf   <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (!r_lane[3]) begin
                        r_lane <= r_lane + 1'b1;
                        r_pos  <= r_pos + 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid          <= 1'b1;
                        o_message_kind   <= r_cmd.kind;
                        o_message_length <= 9'(r_cmd.len);
                        o_word_number    <= 6'(r_word);
                        o_word_bytes     <= r_buf;
                        o_final_word     <= last_word;
                        if (last_word) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_word  <= r_word + 1'b1;
                            r_lane  <= '0;
                            r_buf   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/can_multiframe_reassembler.sv
// CAN multi-frame message reassembler.
// The slave channel takes one received classic CAN frame per request: the
// payload byte count and the eight payload bytes. Start frames open a
// message, data frames with the matching transfer id append to it, and all
// other frames are dropped on acceptance.
// The master channel gives one request per 64-bit message word, with the
// message kind, the message length and the word index beside the data, and
// tlast on the final word of the message.
// A frame is classified in the cycle it is accepted and placed in a
// four-entry command queue; the frame side stalls only when that queue is
// full. The store side then writes one byte per cycle into the message
// buffer. A completed message is read back one buffer byte per cycle
// into a word register, and each finished word is passed to the output
// register when that register is free or being taken by the receiver.
// Reset closes any open message and empties the queue; the buffer contents
// are not cleared. When the receiver stalls, the finished word waits in the
// output register and the store side holds, and the frame side keeps taking
// frames until the queue fills.
module can_multiframe_reassembler #(
    parameter int MAX_MESSAGE_BYTES = cmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // frame_bytes [3:0], frame_payload [67:4], zero fill [71:68]
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // message_kind [7:0], message_length [16:8], word_number [22:17],
    // word_bytes [86:23], zero fill [87]
    output logic [87:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import cmr_pkg::*;

    t_cmd        push_cmd;
    t_cmd        head_cmd;
    logic        push;
    logic        full;
    logic        head_valid;
    logic        pop;
    logic [7:0]  message_kind;
    logic [8:0]  message_length;
    logic [5:0]  word_number;
    logic [63:0] word_bytes;

    cmr_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_frame_bytes  (i_s_axis_tdata[3:0]),
        .i_frame_payload(i_s_axis_tdata[67:4]),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    cmr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(head_valid),
        .o_cmd  (head_cmd)
    );

    cmr_back #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (head_valid),
        .i_cmd           (head_cmd),
        .o_cmd_pop       (pop),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_message_kind  (message_kind),
        .o_message_length(message_length),
        .o_word_number   (word_number),
        .o_word_bytes    (word_bytes),
        .o_final_word    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, word_bytes, word_number, message_length, message_kind};

endmodule
